>>> design/sobel_gradient_magnitude_angle_macros.svh
// Assertion macros for the checker file.
`ifndef SOBEL_GRADIENT_MAGNITUDE_ANGLE_MACROS_SVH
`define SOBEL_GRADIENT_MAGNITUDE_ANGLE_MACROS_SVH

// Checked on every clock edge outside reset.
`define SGMA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("sobel check failed");

// Checked on every clock edge, reset included.
`define SGMA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("sobel reset check failed");

`endif

>>> design/sgma_pkg.sv
package sgma_pkg;

  localparam int CFG_W      = 11;
  localparam int PIX_W      = 8;
  localparam int COORD_W    = 10;
  localparam int GRAD_W     = 11;
  localparam int MAG_W      = 11;
  localparam int ANG_W      = 11;
  localparam int UABS_W     = 10;
  localparam int SIZE_RESET = 1024;
  localparam int SIZE_MIN   = 3;

  localparam int TAB_N      = 512;
  localparam int TAB_AW     = 9;
  localparam int TAB_W      = 50;
  localparam int SPLIT_W    = 25;
  localparam int PROD_HI_W  = UABS_W + TAB_W - SPLIT_W;
  localparam int PROD_LO_W  = UABS_W + SPLIT_W;
  localparam int FULL_W     = UABS_W + TAB_W;
  localparam int SRCH_W     = 10;
  localparam int ANG_MAX    = 512;

  localparam int SQ_W       = 22;
  localparam int SQ_BIT0    = 20;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  typedef logic [TAB_W-1:0] sin_tab_t [TAB_N];

  typedef struct packed {
    logic accept;
    logic shift;
    logic grad;
    logic sqr;
    logic root;
    logic lka;
    logic lkb;
    logic mul;
    logic sum;
    logic cmp;
    logic load;
  } sgma_cmd_t;

  typedef struct packed {
    logic interior;
    logic b_zero;
    logic more;
    logic root_done;
    logic out_free;
  } sgma_sts_t;

  function automatic logic [63:0] mul_q60(logic [63:0] x, logic [63:0] y);
    logic [127:0] p;
    p = {64'd0, x} * {64'd0, y};
    return p[123:60];
  endfunction

  // Restoring long division, only evaluated while the sine table is built.
  function automatic logic [63:0] div_u64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int k = 63; k >= 0; k--) begin
      rem = {rem[63:0], num[k]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[k] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Taylor series of sin at the angle boundaries, Q60 then kept in Q50.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t    tab;
    logic [63:0] step;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    logic [63:0] den;
    step = PI_Q60 >> 11;
    for (int i = 0; i < TAB_N; i++) begin
      x    = step * 64'(2 * i + 1);
      x2   = mul_q60(x, x);
      term = x;
      acc  = x;
      for (int n = 1; n < 30; n++) begin
        if (term != 64'd0) begin
          den  = 64'((2 * n) * (2 * n + 1));
          term = div_u64(mul_q60(term, x2), den);
          if ((n & 1) == 1) begin
            acc = acc - term;
          end else begin
            acc = acc + term;
          end
        end
      end
      tab[i] = acc[59:10];
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

endpackage

>>> design/sgma_ram.sv
module sgma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> design/sgma_ctrl.sv
module sgma_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sgma_pkg::sgma_sts_t sts_i,
  output sgma_pkg::sgma_cmd_t cmd_o
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_READ  = 12'b0000_0000_0010,
    S_SHIFT = 12'b0000_0000_0100,
    S_GRAD  = 12'b0000_0000_1000,
    S_SQR   = 12'b0000_0001_0000,
    S_ROOT  = 12'b0000_0010_0000,
    S_LKA   = 12'b0000_0100_0000,
    S_LKB   = 12'b0000_1000_0000,
    S_MUL   = 12'b0001_0000_0000,
    S_SUM   = 12'b0010_0000_0000,
    S_CMP   = 12'b0100_0000_0000,
    S_FIN   = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        state_d = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        state_d     = sts_i.interior ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd_o.grad = 1'b1;
        state_d    = S_SQR;
      end
      S_SQR: begin
        cmd_o.sqr = 1'b1;
        state_d   = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root = 1'b1;
        state_d    = sts_i.b_zero ? S_FIN : S_LKA;
      end
      S_LKA: begin
        if (sts_i.more) begin
          cmd_o.lka = 1'b1;
          state_d   = S_LKB;
        end else begin
          state_d = S_FIN;
        end
      end
      S_LKB: begin
        cmd_o.lkb = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_LKA;
      end
      S_FIN: begin
        if (sts_i.root_done && sts_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

>>> design/sgma_dp.sv
module sgma_dp #(
  parameter int MAX_SIZE = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sgma_pkg::sgma_cmd_t            cmd_i,
  output sgma_pkg::sgma_sts_t            sts_o,
  input  logic                           cfg_we_i,
  input  logic [sgma_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic [sgma_pkg::PIX_W-1:0]     pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sgma_pkg::COORD_W-1:0]   center_row_o,
  output logic [sgma_pkg::COORD_W-1:0]   center_col_o,
  output logic signed [sgma_pkg::GRAD_W-1:0] grad_a_o,
  output logic signed [sgma_pkg::GRAD_W-1:0] grad_b_o,
  output logic [sgma_pkg::MAG_W-1:0]     magnitude_o,
  output logic signed [sgma_pkg::ANG_W-1:0]  angle_o,
  output logic                           frame_end_o
);

  localparam int AW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int SW_MX = $clog2(MAX_SIZE + 1);
  localparam int SW    = (SW_MX > sgma_pkg::CFG_W) ? SW_MX : sgma_pkg::CFG_W;
  localparam int PW    = sgma_pkg::PIX_W;
  localparam int GW    = sgma_pkg::GRAD_W;
  localparam int QW    = sgma_pkg::SQ_W;
  localparam int UW    = sgma_pkg::UABS_W;
  localparam int XW    = sgma_pkg::SRCH_W;
  localparam int TW    = sgma_pkg::TAB_W;
  localparam int LW    = sgma_pkg::SPLIT_W;

  // Frame position and size
  logic [sgma_pkg::CFG_W-1:0] size_q;
  logic [AW-1:0]              row_q, col_q;
  logic [SW-1:0]              size_ext, size_eff, last_idx;
  logic                       col_last, row_last;

  always_comb begin
    size_ext = SW'(size_q);
    if (size_ext < SW'(sgma_pkg::SIZE_MIN)) begin
      size_eff = SW'(sgma_pkg::SIZE_MIN);
    end else if (size_ext > SW'(MAX_SIZE)) begin
      size_eff = SW'(MAX_SIZE);
    end else begin
      size_eff = size_ext;
    end
    last_idx = size_eff - SW'(1);
    col_last = (SW'(col_q) == last_idx);
    row_last = (SW'(row_q) == last_idx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= sgma_pkg::CFG_W'(sgma_pkg::SIZE_RESET);
      row_q  <= '0;
      col_q  <= '0;
    end else if (cfg_we_i) begin
      size_q <= cfg_data_i;
      row_q  <= '0;
      col_q  <= '0;
    end else if (cmd_i.shift) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + AW'(1);
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // Line stores
  logic [PW-1:0] pix_q, up_rd, mid_rd;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pix_q <= pixel_i;
    end
  end

  sgma_ram #(.WIDTH(PW), .DEPTH(MAX_SIZE)) u_ram_upper (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.shift),
    .wr_addr_i (col_q),
    .wr_data_i (mid_rd),
    .rd_en_i   (cmd_i.accept),
    .rd_addr_i (col_q),
    .rd_data_o (up_rd)
  );

  sgma_ram #(.WIDTH(PW), .DEPTH(MAX_SIZE)) u_ram_middle (
    .clk_i     (clk_i),
    .wr_en_i   (cmd_i.shift),
    .wr_addr_i (col_q),
    .wr_data_i (pix_q),
    .rd_en_i   (cmd_i.accept),
    .rd_addr_i (col_q),
    .rd_data_o (mid_rd)
  );

  // Window, oldest row in 0..2
  logic [PW-1:0] win_q [9];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        win_q[k] <= '0;
      end
    end else if (cmd_i.shift) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= up_rd;
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= mid_rd;
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= pix_q;
    end
  end

  // Center position of the pending result
  logic [sgma_pkg::COORD_W-1:0] crow_q, ccol_q;
  logic                         fend_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.shift) begin
      crow_q <= sgma_pkg::COORD_W'(row_q - AW'(1));
      ccol_q <= sgma_pkg::COORD_W'(col_q - AW'(1));
      fend_q <= col_last && row_last;
    end
  end

  // Gradients
  logic signed [GW:0]   w_s [9];
  logic signed [GW:0]   ga_full, gb_full;
  logic signed [GW-1:0] a_q, b_q;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      w_s[k] = $signed({{(GW + 1 - PW){1'b0}}, win_q[k]});
    end
    ga_full = (w_s[6] + (w_s[7] <<< 1) + w_s[8]) - (w_s[0] + (w_s[1] <<< 1) + w_s[2]);
    gb_full = (w_s[2] + (w_s[5] <<< 1) + w_s[8]) - (w_s[0] + (w_s[3] <<< 1) + w_s[6]);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.grad) begin
      a_q <= ga_full[GW-1:0];
      b_q <= gb_full[GW-1:0];
    end
  end

  // Squares and absolute values
  logic signed [QW-1:0] sqa, sqb;
  logic signed [GW-1:0] na, nb;
  logic [QW-1:0]        sqa_q, sqb_q;
  logic [UW-1:0]        ua_q, ub_q;
  logic                 neg_q, a_neg_q;

  assign sqa = a_q * a_q;
  assign sqb = b_q * b_q;
  assign na  = a_q[GW-1] ? -a_q : a_q;
  assign nb  = b_q[GW-1] ? -b_q : b_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqr) begin
      sqa_q   <= sqa;
      sqb_q   <= sqb;
      ua_q    <= na[UW-1:0];
      ub_q    <= nb[UW-1:0];
      neg_q   <= a_q[GW-1] ^ b_q[GW-1];
      a_neg_q <= a_q[GW-1];
    end
  end

  // Square root, one digit pair a cycle
  logic [QW-1:0] rad_q, res_q, bit_q, trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= '0;
    end else if (cmd_i.root) begin
      bit_q <= QW'(1) << sgma_pkg::SQ_BIT0;
    end else if (bit_q != '0) begin
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.root) begin
      rad_q <= sqa_q + sqb_q;
      res_q <= '0;
    end else if (bit_q != '0) begin
      if (rad_q >= trial) begin
        rad_q <= rad_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
    end
  end

  // Angle: binary search over the sine boundaries
  logic [XW-1:0]                       lo_q, hi_q, mid;
  logic [sgma_pkg::TAB_AW-1:0]         mid_ix, mirror_ix;
  logic [TW-1:0]                       sn_q, sd_q;
  logic [sgma_pkg::PROD_HI_W-1:0]      pah_q, pbh_q;
  logic [sgma_pkg::PROD_LO_W-1:0]      pal_q, pbl_q;
  logic [sgma_pkg::FULL_W-1:0]         fa_q, fb_q;

  assign mid       = XW'((XW + 1)'(lo_q) + (XW + 1)'(hi_q) >> 1);
  assign mid_ix    = mid[sgma_pkg::TAB_AW-1:0];
  assign mirror_ix = sgma_pkg::TAB_AW'(sgma_pkg::TAB_N - 1) - mid_ix;

  always_ff @(posedge clk_i) begin
    if (cmd_i.root) begin
      lo_q <= '0;
      hi_q <= XW'(sgma_pkg::ANG_MAX);
    end else if (cmd_i.cmp) begin
      if (fa_q > fb_q) begin
        lo_q <= mid + XW'(1);
      end else begin
        hi_q <= mid;
      end
    end
    if (cmd_i.lka) begin
      sn_q <= sgma_pkg::SIN_TAB[mirror_ix];
    end
    if (cmd_i.lkb) begin
      sd_q <= sgma_pkg::SIN_TAB[mid_ix];
    end
    if (cmd_i.mul) begin
      pah_q <= ua_q * sn_q[TW-1:LW];
      pal_q <= ua_q * sn_q[LW-1:0];
      pbh_q <= ub_q * sd_q[TW-1:LW];
      pbl_q <= ub_q * sd_q[LW-1:0];
    end
    if (cmd_i.sum) begin
      fa_q <= (sgma_pkg::FULL_W'(pah_q) << LW) + sgma_pkg::FULL_W'(pal_q);
      fb_q <= (sgma_pkg::FULL_W'(pbh_q) << LW) + sgma_pkg::FULL_W'(pbl_q);
    end
  end

  logic signed [sgma_pkg::ANG_W-1:0] ang, lo_s;

  always_comb begin
    lo_s = $signed(sgma_pkg::ANG_W'(lo_q));
    if (ub_q == '0) begin
      if (ua_q == '0) begin
        ang = '0;
      end else begin
        ang = a_neg_q ? -sgma_pkg::ANG_W'(sgma_pkg::ANG_MAX) : sgma_pkg::ANG_W'(sgma_pkg::ANG_MAX);
      end
    end else begin
      ang = neg_q ? -lo_s : lo_s;
    end
  end

  // Output register
  logic ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.load) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      center_row_o <= crow_q;
      center_col_o <= ccol_q;
      grad_a_o     <= a_q;
      grad_b_o     <= b_q;
      magnitude_o  <= res_q[sgma_pkg::MAG_W-1:0];
      angle_o      <= ang;
      frame_end_o  <= fend_q;
    end
  end

  assign out_valid_o = ov_q;

  assign sts_o.interior  = (row_q >= AW'(2)) && (col_q >= AW'(2));
  assign sts_o.b_zero    = (b_q == '0);
  assign sts_o.more      = (lo_q < hi_q);
  assign sts_o.root_done = (bit_q == '0);
  assign sts_o.out_free  = !ov_q || out_ready_i;

endmodule

>>> design/sobel_gradient_magnitude_angle.sv
// Channel  | Direction | Handshake                        | Payload
// ---------+-----------+----------------------------------+-----------------------------------
// s_axis   | in        | s_axis_tvalid_i / s_axis_tready_o | tdata[7:0] pixel
// m_axis   | out       | m_axis_tvalid_o / m_axis_tready_i | tdata center_row..angle, tlast
// cfg      | in        | cfg_valid_i / cfg_ready_o         | cfg_data_i frame side length
//
// A border pixel passes through the read and shift states and then returns to idle.
// For an interior pixel, a zero grad_b only waits out the eleven-step square root;
// otherwise the angle binary search runs nine or ten probes, each made of two sine
// table reads, a split multiply, a sum and a compare; the square root runs alongside,
// one digit pair a cycle. Reset clears the window, the frame position and the output
// valid; the line stores are not cleared. A finished result waits in the output
// register while the next pixel is taken; only the final step of the next result holds
// for m_axis_tready_i.
module sobel_gradient_magnitude_angle #(
  parameter int MAX_SIZE = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // pixel stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] pixel
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [9:0] center_row, [19:10] center_col, [30:20] grad_a, [41:31] grad_b,
  // [52:42] magnitude, [63:53] angle
  output logic [63:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,   // frame_end
  // image size register
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_data_i
);

  sgma_pkg::sgma_cmd_t cmd;
  sgma_pkg::sgma_sts_t sts;

  logic [sgma_pkg::COORD_W-1:0]      center_row, center_col;
  logic signed [sgma_pkg::GRAD_W-1:0] grad_a, grad_b;
  logic [sgma_pkg::MAG_W-1:0]        magnitude;
  logic signed [sgma_pkg::ANG_W-1:0]  angle;
  logic                              frame_end;

  // The user must issue register writes only while idle; the block does not enforce this and takes them at once.
  assign cfg_ready_o = 1'b1;

  sgma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sgma_dp #(.MAX_SIZE(MAX_SIZE)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_i      (s_axis_tdata_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .center_row_o (center_row),
    .center_col_o (center_col),
    .grad_a_o     (grad_a),
    .grad_b_o     (grad_b),
    .magnitude_o  (magnitude),
    .angle_o      (angle),
    .frame_end_o  (frame_end)
  );

  // Pack result fields, first field in the low bits.
  assign m_axis_tdata_o = {angle, magnitude, grad_b, grad_a, center_col, center_row};
  assign m_axis_tlast_o = frame_end;

endmodule

>>> design/sgma_checker.sv
`include "sobel_gradient_magnitude_angle_macros.svh"

module sgma_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [63:0] m_axis_tdata_o,
  input logic        m_axis_tlast_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o,
  input logic [10:0] cfg_data_i
);

  // A stalled result holds.
  `SGMA_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

  // One pixel at a time: ready drops after each transaction.
  `SGMA_ASSERT(a_in_one_at_a_time, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)

  // Magnitude never exceeds the largest possible gradient length.
  `SGMA_ASSERT(a_mag_range, m_axis_tvalid_o |-> m_axis_tdata_o[52:42] <= 11'd1443)

  // Angle stays within a quarter turn either way.
  `SGMA_ASSERT(a_ang_range, m_axis_tvalid_o |-> $signed(m_axis_tdata_o[63:53]) >= -11'sd512 && $signed(m_axis_tdata_o[63:53]) <= 11'sd512)

  // A clock edge in reset leaves no result showing after it.
  `SGMA_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind sobel_gradient_magnitude_angle sgma_checker u_sgma_checker (.*);
